// File: hdl/bmst_pkg.sv
`timescale 1ns / 1ps
package bmst_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int COST_BITS_DEF    = 16;
    localparam int VTX_W    = 7;
    localparam int NUM_W    = 8;
    localparam int WGT_W    = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic [1:0] ADDR_VERTEX_COUNT = 2'd0;

    typedef struct packed {
        logic             kind;
        logic [VTX_W-1:0] end_a;
        logic [VTX_W-1:0] end_b;
        logic [WGT_W-1:0] weight;
        logic [NUM_W-1:0] num;
        logic             connected;
        logic             overflow;
    } result_t;
endpackage

// File: hdl/boruvka_mst_engine_core.sv
`timescale 1ns / 1ps
// Boruvka spanning tree engine. Edge words load at one per cycle; the final edge starts a run
// and s_tready stays low until the run's status word has been registered.
// Each round: clear the cheapest table; per edge in the vertex range, walk both ends to roots
// and, for two trees, offer it to each root's cheapest entry. Merge: per root with a cheapest
// edge, walk its ends again; for two trees, link them and emit it, waiting out output stalls.
// Reset (rst_n low, async) idles control, sets vertex_count to 64; memories vary.
module boruvka_mst_engine_core
    import bmst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    parameter int COST_BITS    = COST_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: end_a[7], end_b[7], weight[16], final_edge[1], zero pad
    input  logic [bmst_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: tree_end_a[7], tree_end_b[7], tree_weight[16], edge_number[8], pad
    output logic [bmst_pkg::OUT_TDATA_W-1:0] m_tdata,
    // tuser from bit 0: kind, connected, overflow
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import bmst_pkg::*;

    localparam int VI_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int VC_W = $clog2(MAX_VERTICES + 1);
    localparam int ENT_W = 2 * VTX_W + COST_BITS;
    localparam int CH_W = 1 + EI_W + COST_BITS;

    localparam logic [3:0] S_LOAD = 4'd0, S_CLR = 4'd1, S_ERD = 4'd2, S_EWT = 4'd3,
        S_FIND = 4'd4, S_FWT = 4'd5, S_CRD = 4'd6, S_CUPD = 4'd7, S_MRD = 4'd8,
        S_MWT = 4'd9, S_OUT = 4'd10, S_STAT = 4'd11, S_NEXT = 4'd12;

    // Memories: edge store, parent table, and the cheapest-edge table whose entries
    // hold a valid bit on top, then the edge index, then that edge's cost.
    logic [ENT_W-1:0] edge_mem [MAX_EDGES];
    logic [VI_W-1:0]  par_mem [MAX_VERTICES];
    logic [CH_W-1:0]  chp_mem [MAX_VERTICES];

    logic [3:0]       state_reg;
    logic [VTX_W-1:0] vcount_reg;
    logic [EC_W-1:0]  etotal_reg;
    logic             ovf_reg;
    logic [VC_W-1:0]  trees_reg;
    logic             added_reg;
    logic             init_reg;      // parent table reinit in progress
    logic [EI_W-1:0]  eidx_reg;
    logic [VI_W-1:0]  vidx_reg;
    logic [ENT_W-1:0] ent_reg;
    logic [EI_W-1:0]  ent_num_reg;
    logic [VI_W-1:0]  walk_reg, ra_reg, rb_reg;
    logic             side_reg;      // 0 walking end A, 1 walking end B
    logic [VC_W-1:0]  steps_reg;
    logic             merge_reg;     // root walk serves merge phase
    logic             cside_reg;     // cheapest update for ra then rb
    logic [CH_W-1:0]  chp_q_reg;
    logic [ENT_W-1:0] edge_q_reg;
    logic [VI_W-1:0]  par_q_reg;
    result_t          res_reg;
    logic             m_valid_reg;

    // Vertex count in use: zero counts as one, large settings clip to the table size.
    logic [VC_W-1:0] nv;
    always_comb
    begin
        nv = (vcount_reg == '0) ? VC_W'(1) :
             (int'(vcount_reg) > MAX_VERTICES) ? VC_W'(MAX_VERTICES) :
             VC_W'(vcount_reg);
    end

    wire in_acc = s_tvalid && s_tready;
    // Loading needs no output slot, so a pending status word does not hold off the next graph.
    assign s_tready = (state_reg == S_LOAD);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_VERTEX_COUNT) ? {{(32-VTX_W){1'b0}}, vcount_reg} : 32'd0;

    wire [VTX_W-1:0] ea = ent_reg[VTX_W-1:0];
    wire [VTX_W-1:0] eb = ent_reg[2*VTX_W-1:VTX_W];
    wire [COST_BITS-1:0] ew = ent_reg[ENT_W-1:2*VTX_W];
    wire usable = (ea != '0) && (VC_W'(ea) <= nv) && (eb != '0) && (VC_W'(eb) <= nv);

    // Memory ports.
    logic             par_we;  logic [VI_W-1:0] par_wa, par_wd, par_ra;
    logic             chp_we;  logic [VI_W-1:0] chp_wa, chp_ra; logic [CH_W-1:0] chp_wd;
    logic [EI_W-1:0]  edge_ra;

    always_ff @(posedge clk)
    begin
        if (in_acc && (etotal_reg < EC_W'(MAX_EDGES)))
            edge_mem[etotal_reg[EI_W-1:0]] <= {COST_BITS'(s_tdata[29:14]),
                                              s_tdata[13:7], s_tdata[6:0]};
        edge_q_reg <= edge_mem[edge_ra];
        if (par_we)
            par_mem[par_wa] <= par_wd;
        par_q_reg <= par_mem[par_ra];
        if (chp_we)
            chp_mem[chp_wa] <= chp_wd;
        chp_q_reg <= chp_mem[chp_ra];
    end

    // A cheapest entry is read in S_CRD and rewritten in S_CUPD; the next read is
    // issued in the state that follows that write, so read-modify-write never overlaps.
    always_comb
    begin
        par_we = 1'b0; par_wa = vidx_reg; par_wd = vidx_reg; par_ra = walk_reg;
        chp_we = 1'b0; chp_wa = vidx_reg; chp_wd = '0;
        chp_ra = cside_reg ? rb_reg : ra_reg;
        edge_ra = eidx_reg;
        if (init_reg && state_reg == S_CLR)
            par_we = 1'b1;
        if (state_reg == S_CLR)
            chp_we = 1'b1;
        if (state_reg == S_MRD)
            chp_ra = vidx_reg;
        if (state_reg == S_CUPD)
        begin
            chp_wa = cside_reg ? rb_reg : ra_reg;
            chp_wd = {1'b1, eidx_reg, ew};
            // Strictly lower cost only, so the first of equal edges is kept.
            chp_we = !chp_q_reg[CH_W-1] || (chp_q_reg[COST_BITS-1:0] > ew);
        end
        if (state_reg == S_OUT && !m_valid_reg)
        begin
            par_we = 1'b1; par_wa = rb_reg; par_wd = ra_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD; vcount_reg <= VTX_W'(64); etotal_reg <= '0;
            ovf_reg <= 1'b0; trees_reg <= '0; added_reg <= 1'b0; init_reg <= 1'b0;
            eidx_reg <= '0; vidx_reg <= '0; side_reg <= 1'b0; steps_reg <= '0;
            merge_reg <= 1'b0; cside_reg <= 1'b0; m_valid_reg <= 1'b0;
            ent_reg <= '0; ent_num_reg <= '0; walk_reg <= '0; ra_reg <= '0; rb_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT)
                vcount_reg <= pwdata[VTX_W-1:0];
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                    if (in_acc)
                    begin
                        if (etotal_reg < EC_W'(MAX_EDGES))
                            etotal_reg <= etotal_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (s_tdata[30])
                        begin
                            trees_reg <= nv; vidx_reg <= '0; init_reg <= 1'b1;
                            state_reg <= S_CLR;
                        end
                    end
                S_CLR:
                begin
                    // Parent reinit shares this sweep on the first round.
                    if (vidx_reg == VI_W'(MAX_VERTICES - 1))
                    begin
                        init_reg <= 1'b0; vidx_reg <= '0; eidx_reg <= '0;
                        added_reg <= 1'b0; merge_reg <= 1'b0;
                        state_reg <= (trees_reg > VC_W'(1)) ? S_ERD : S_STAT;
                    end
                    else
                        vidx_reg <= vidx_reg + 1'b1;
                end
                S_ERD: state_reg <= S_EWT;
                S_EWT:
                begin
                    ent_reg <= edge_q_reg; ent_num_reg <= eidx_reg;
                    state_reg <= S_FIND; side_reg <= 1'b0; steps_reg <= '0;
                    walk_reg <= VI_W'(edge_q_reg[VTX_W-1:0] - 1'b1);
                end
                S_FIND:
                    if (!merge_reg && !usable)
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_FWT;
                S_FWT:
                    if (par_q_reg != walk_reg && steps_reg < VC_W'(MAX_VERTICES))
                    begin
                        walk_reg <= par_q_reg; steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_FIND;
                    end
                    else if (!side_reg)
                    begin
                        ra_reg <= walk_reg; side_reg <= 1'b1; steps_reg <= '0;
                        walk_reg <= VI_W'(eb - 1'b1); state_reg <= S_FIND;
                    end
                    else
                    begin
                        rb_reg <= walk_reg; cside_reg <= 1'b0;
                        if (walk_reg == ra_reg)
                            state_reg <= S_NEXT;
                        else
                            state_reg <= merge_reg ? S_OUT : S_CRD;
                    end
                S_CRD: state_reg <= S_CUPD;
                S_CUPD:
                    if (!cside_reg)
                    begin
                        cside_reg <= 1'b1; state_reg <= S_CRD;
                    end
                    else
                    begin
                        cside_reg <= 1'b0; state_reg <= S_NEXT;
                    end
                S_MRD: state_reg <= S_MWT;
                S_MWT:
                    if (chp_q_reg[CH_W-1])
                    begin
                        eidx_reg <= chp_q_reg[COST_BITS +: EI_W]; state_reg <= S_ERD;
                    end
                    else
                        state_reg <= S_NEXT;
                S_OUT:
                    if (!m_valid_reg)
                    begin
                        res_reg <= '{kind: KIND_EDGE, end_a: ea, end_b: eb,
                                     weight: WGT_W'(ew), num: NUM_W'(ent_num_reg),
                                     connected: 1'b0, overflow: 1'b0};
                        m_valid_reg <= 1'b1; trees_reg <= trees_reg - 1'b1;
                        added_reg <= 1'b1; state_reg <= S_NEXT;
                    end
                S_NEXT:
                    if (merge_reg)
                    begin
                        // Merge pass: after the last vertex, start another round or finish; else go to the next vertex.
                        if (VC_W'(vidx_reg) + VC_W'(1) >= nv)
                        begin
                            vidx_reg <= '0;
                            state_reg <= (added_reg && trees_reg > VC_W'(1)) ? S_CLR : S_STAT;
                        end
                        else
                        begin
                            vidx_reg <= vidx_reg + 1'b1; state_reg <= S_MRD;
                        end
                    end
                    else if (eidx_reg == EI_W'(etotal_reg - 1'b1))
                    begin
                        merge_reg <= 1'b1; vidx_reg <= '0; state_reg <= S_MRD;
                    end
                    else
                    begin
                        eidx_reg <= eidx_reg + 1'b1; state_reg <= S_ERD;
                    end
                S_STAT:
                    if (!m_valid_reg)
                    begin
                        res_reg <= '{kind: KIND_STATUS, end_a: '0, end_b: '0, weight: '0,
                                     num: '0, connected: (trees_reg == VC_W'(1)),
                                     overflow: ovf_reg};
                        m_valid_reg <= 1'b1; etotal_reg <= '0; ovf_reg <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'd0, res_reg.num, res_reg.weight, res_reg.end_b, res_reg.end_a};
    assign m_tuser  = {res_reg.overflow, res_reg.connected, res_reg.kind};
    assign m_tlast  = res_reg.kind;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !s_tready)
        else $error("input taken while a run is active");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result word changed");
    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STAT && !m_valid_reg) |=> (etotal_reg == '0))
        else $error("edge count not cleared at run end");
`endif
endmodule
